/* src/plwt_pkg.sv */
// ----------------------------------------------------------------------------
// plwt_pkg
// Shared types, constants and helpers of the packet loss window tracker.
// ----------------------------------------------------------------------------
package plwt_pkg;

	localparam int RING_DEPTH    = 128;
	localparam int SEQ_STEP      = 2;
	localparam int MAX_JUMP      = 128;
	localparam int REPORT_WINDOW = 64;
	localparam int WALK_STEP     = 2;
	localparam int PM_SCALE      = 1000;
	localparam int NUM_STATS     = 12;

	localparam int ADDR_W  = $clog2(RING_DEPTH);
	localparam int WIDX_W  = $clog2(REPORT_WINDOW + 1);
	localparam int SMALL_W = $clog2(2 * REPORT_WINDOW + 1);
	localparam int CNT_W   = 16 + WIDX_W;
	localparam int NUM_W   = SMALL_W + 10;
	localparam int DEN_W   = WIDX_W;

	localparam logic [19:0] COUNT_MAX = 20'hFFFFF;

	localparam logic [2:0] OP_RECORD = 3'd0;
	localparam logic [2:0] OP_COUNT  = 3'd1;
	localparam logic [2:0] OP_MARK   = 3'd2;
	localparam logic [2:0] OP_QUERY  = 3'd3;
	localparam logic [2:0] OP_REPORT = 3'd4;

	localparam logic [3:0] ST_INIT      = 4'd0;
	localparam logic [3:0] ST_LOSS      = 4'd1;
	localparam logic [3:0] ST_SUCC      = 4'd2;
	localparam logic [3:0] ST_RS_OK     = 4'd3;
	localparam logic [3:0] ST_RS_EXCESS = 4'd4;
	localparam logic [3:0] ST_RS_LATE   = 4'd5;
	localparam logic [3:0] ST_RS_ERROR  = 4'd6;
	localparam logic [3:0] ST_REAL_LOSS = 4'd7;

	localparam logic [3:0] SID_TOTAL   = 4'd0;
	localparam logic [3:0] SID_UNINIT  = 4'd1;
	localparam logic [3:0] SID_LOSS    = 4'd2;
	localparam logic [3:0] SID_FIRST   = 4'd3;
	localparam logic [3:0] SID_RS_OK   = 4'd4;
	localparam logic [3:0] SID_RS_LATE = 4'd5;
	localparam logic [3:0] SID_RS_ERR  = 4'd6;
	localparam logic [3:0] SID_EXCESS  = 4'd7;
	localparam logic [3:0] SID_SUCC    = 4'd8;
	localparam logic [3:0] SID_EMPTIES = 4'd9;
	localparam logic [3:0] SID_SPEAKER = 4'd10;
	localparam logic [3:0] SID_GETS    = 4'd11;

	typedef struct packed {
		logic [2:0]  op;
		logic [31:0] seq;
		logic        is_loss;
		logic        is_resend;
	} req_t;

	typedef struct packed {
		logic        kind;
		logic        need_resend;
		logic        tracking;
		logic [3:0]  stat_id;
		logic [19:0] count;
		logic [9:0]  per_mille;
		logic [31:0] span_first;
		logic [31:0] span_last;
		logic        last;
	} rsp_t;

	typedef struct packed {
		logic [2:0]  op;
		logic [31:0] seq;
		logic [3:0]  st;
	} cmd_t;

	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} queue_out_t;

	typedef struct packed {
		logic [3:0]  status;
		logic [31:0] seq;
		logic [15:0] ecnt;
	} entry_t;

	function automatic logic [ADDR_W-1:0] slot_of(input logic [31:0] s);
		logic [31:0] q;
		q = s / SEQ_STEP;
		return q[ADDR_W-1:0];
	endfunction

endpackage

/* src/plwt_ram.sv */
// ----------------------------------------------------------------------------
// plwt_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module plwt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* src/plwt_front.sv */
// ----------------------------------------------------------------------------
// plwt_front
// Accept items, drop unknown ops, derive the status code, queue two deep.
// ----------------------------------------------------------------------------
module plwt_front
	import plwt_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  req_t       req,
	input  logic       pop,
	output queue_out_t qout
);

	cmd_t       fifo_q [2];
	logic       wptr_q;
	logic       rptr_q;
	logic [1:0] fill_q;
	logic       acc;
	logic       push;
	logic       do_pop;
	logic [3:0] st;

	assign busy   = (fill_q == 2'd2);
	assign acc    = start && !busy;
	assign push   = acc && (req.op <= OP_REPORT);
	assign do_pop = pop && (fill_q != 2'd0);

	// an empty count that opens a new entry records it as a loss
	always_comb begin
		if (req.op == OP_COUNT) begin
			st = ST_LOSS;
		end else if (req.is_resend) begin
			st = req.is_loss ? ST_RS_LATE : ST_RS_OK;
		end else begin
			st = req.is_loss ? ST_REAL_LOSS : ST_SUCC;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wptr_q] <= '{op: req.op, seq: req.seq, st: st};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			fill_q <= 2'd0;
		end else begin
			if (push) begin
				wptr_q <= !wptr_q;
			end
			if (do_pop) begin
				rptr_q <= !rptr_q;
			end
			fill_q <= fill_q + {1'b0, push} - {1'b0, do_pop};
		end
	end

	assign qout.valid = (fill_q != 2'd0);
	assign qout.cmd   = fifo_q[rptr_q];

endmodule

/* src/plwt_div.sv */
// ----------------------------------------------------------------------------
// plwt_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module plwt_div
	import plwt_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [NUM_W-1:0] quot
);

	localparam int CW = $clog2(NUM_W + 1);

	logic [DEN_W:0]   rem_q;
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W-1:0] den_q;
	logic [CW-1:0]    cnt_q;
	logic             run_q;
	logic             done_q;
	logic [DEN_W+1:0] trial;

	assign trial = {rem_q, quo_q[NUM_W-1]};

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (run_q) begin
			if (trial >= {2'b00, den_q}) begin
				rem_q <= (DEN_W+1)'(trial - {2'b00, den_q});
				quo_q <= {quo_q[NUM_W-2:0], 1'b1};
			end else begin
				rem_q <= trial[DEN_W:0];
				quo_q <= {quo_q[NUM_W-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CW'(NUM_W);
			end else if (run_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign quot = quo_q;

endmodule

/* src/plwt_back.sv */
// ----------------------------------------------------------------------------
// plwt_back
// Execute queued items against the ring: record, gap fill, marks, queries
// and the report walk with per-mille division.
// ----------------------------------------------------------------------------
module plwt_back
	import plwt_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  queue_out_t qin,
	output logic       pop,
	output logic       rsp_valid,
	output rsp_t       rsp
);

	localparam logic [4:0] S_IDLE = 5'd0;
	localparam logic [4:0] S_P1   = 5'd1;
	localparam logic [4:0] S_P1D  = 5'd2;
	localparam logic [4:0] S_N    = 5'd3;
	localparam logic [4:0] S_ND   = 5'd4;
	localparam logic [4:0] S_R    = 5'd5;
	localparam logic [4:0] S_RD   = 5'd6;
	localparam logic [4:0] S_GAP  = 5'd7;
	localparam logic [4:0] S_WR   = 5'd8;
	localparam logic [4:0] S_M2   = 5'd9;
	localparam logic [4:0] S_MK   = 5'd10;
	localparam logic [4:0] S_MKD  = 5'd11;
	localparam logic [4:0] S_W    = 5'd12;
	localparam logic [4:0] S_WFIN = 5'd13;
	localparam logic [4:0] S_EM   = 5'd14;
	localparam logic [4:0] S_ED   = 5'd15;
	localparam logic [4:0] S_EO   = 5'd16;

	logic [4:0]              state_q;
	logic [31:0]             s_q;
	logic [3:0]              st_q;
	logic [ADDR_W-1:0]       pos_q;
	logic                    flag1_q;
	logic                    updn_q;
	logic [31:0]             newest_q;
	logic [ADDR_W-1:0]       gi_q;
	logic [31:0]             gp_q;
	logic [RING_DEPTH-1:0]   vmain_q;
	logic [RING_DEPTH-1:0]   vmark_q;
	logic                    vmain_rd_q;
	logic                    vmark_rd_q;
	logic [WIDX_W-1:0]       walk_q;
	logic                    pend_q;
	logic [CNT_W-1:0]        cnt_q [NUM_STATS];
	logic [31:0]             first_q;
	logic [31:0]             lastv_q;
	logic [3:0]              k_q;
	logic [9:0]              pm_q;
	logic                    rsp_valid_q;
	rsp_t                    rsp_q;

	// RAM ports
	logic                    m_we;
	logic [ADDR_W-1:0]       m_waddr;
	entry_t                  m_wdata;
	logic                    m_re;
	logic [ADDR_W-1:0]       raddr;
	entry_t                  m_rdata;
	logic                    k_we;
	logic [31:0]             k_rdata;
	logic                    k_re;
	logic                    clr;

	// effective read fields, invalid entries read as zero
	logic [3:0]              e_st;
	logic [31:0]             e_seq;
	logic [15:0]             e_ecnt;
	logic [31:0]             e_mark;
	logic [31:0]             jump_dist;
	logic [3:0]              up_st;
	logic [31:0]             walk_seq;
	logic [19:0]             sel_cnt;
	logic [NUM_W-1:0]        div_num;
	logic                    div_start;
	logic                    div_done;
	logic [NUM_W-1:0]        div_quot;
	logic [CNT_W-1:0]        c0;

	assign e_st   = vmain_rd_q ? m_rdata.status : ST_INIT;
	assign e_seq  = vmain_rd_q ? m_rdata.seq : 32'd0;
	assign e_ecnt = vmain_rd_q ? m_rdata.ecnt : 16'd0;
	assign e_mark = vmark_rd_q ? k_rdata : 32'd0;
	assign jump_dist = (s_q > newest_q) ? (s_q - newest_q) : (newest_q - s_q);
	assign walk_seq = s_q - 32'(walk_q) * 32'(WALK_STEP);
	assign c0     = cnt_q[SID_TOTAL];

	always_comb begin
		if (e_st != ST_RS_OK && e_st != ST_SUCC) begin
			up_st = st_q;
		end else if (e_st == ST_SUCC && st_q == ST_RS_LATE) begin
			up_st = ST_RS_EXCESS;
		end else begin
			up_st = e_st;
		end
	end

	always_comb begin
		if (cnt_q[k_q] > CNT_W'(COUNT_MAX)) begin
			sel_cnt = COUNT_MAX;
		end else begin
			sel_cnt = cnt_q[k_q][19:0];
		end
		div_num   = NUM_W'(sel_cnt[SMALL_W-1:0]) * NUM_W'(PM_SCALE);
		div_start = (state_q == S_EM) && (k_q != SID_EMPTIES) && (c0 != '0);
	end

	// RAM port drive per state
	always_comb begin
		m_we    = 1'b0;
		m_waddr = pos_q;
		m_wdata = '{status: ST_INIT, seq: 32'd0, ecnt: 16'd0};
		m_re    = 1'b0;
		k_re    = 1'b0;
		k_we    = 1'b0;
		raddr   = pos_q;
		clr     = 1'b0;
		unique case (state_q) inside
			S_P1, S_R: begin
				m_re = 1'b1;
			end
			S_N: begin
				raddr = slot_of(newest_q);
				m_re  = (newest_q != 32'd0);
			end
			S_P1D: begin
				if (e_seq == s_q) begin
					m_we    = 1'b1;
					m_wdata = '{status: e_st, seq: e_seq,
						ecnt: (e_ecnt != 16'hFFFF) ? e_ecnt + 16'd1 : e_ecnt};
				end
			end
			S_ND: begin
				if (e_seq != newest_q || jump_dist > 32'(MAX_JUMP)) begin
					clr     = 1'b1;
					m_we    = flag1_q;
					m_wdata = '{status: ST_INIT, seq: 32'd0, ecnt: 16'd1};
				end
			end
			S_RD: begin
				if (e_seq == s_q) begin
					m_we    = 1'b1;
					m_wdata = '{status: up_st, seq: e_seq,
						ecnt: flag1_q ? 16'd1 : e_ecnt};
				end
			end
			S_GAP: begin
				if (gi_q != pos_q) begin
					m_we    = 1'b1;
					m_waddr = gi_q;
					m_wdata = '{status: ST_LOSS, seq: gp_q + 32'(SEQ_STEP), ecnt: 16'd0};
				end
			end
			S_WR: begin
				m_we    = 1'b1;
				m_wdata = '{status: st_q, seq: s_q, ecnt: flag1_q ? 16'd1 : 16'd0};
			end
			S_M2: begin
				k_we = 1'b1;
			end
			S_MK: begin
				k_re = 1'b1;
			end
			S_W: begin
				raddr = slot_of(walk_seq);
				m_re  = (walk_q < WIDX_W'(REPORT_WINDOW));
				k_re  = m_re;
			end
			default: begin
			end
		endcase
	end

	assign pop = (state_q == S_IDLE) && qin.valid;

	plwt_ram #(.WIDTH($bits(entry_t)), .DEPTH(RING_DEPTH)) u_main (
		.clk   (clk),
		.we    (m_we),
		.waddr (m_waddr),
		.wdata (m_wdata),
		.re    (m_re),
		.raddr (raddr),
		.rdata (m_rdata)
	);

	plwt_ram #(.WIDTH(32), .DEPTH(RING_DEPTH)) u_mark (
		.clk   (clk),
		.we    (k_we),
		.waddr (pos_q),
		.wdata (s_q),
		.re    (k_re),
		.raddr (raddr),
		.rdata (k_rdata)
	);

	plwt_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (c0[DEN_W-1:0]),
		.done   (div_done),
		.quot   (div_quot)
	);

	// payload registers
	always_ff @(posedge clk) begin
		if (pop) begin
			s_q   <= qin.cmd.seq;
			st_q  <= qin.cmd.st;
			pos_q <= slot_of(qin.cmd.seq);
		end
		if (state_q == S_RD) begin
			gi_q <= slot_of(newest_q) + ADDR_W'(1);
			gp_q <= newest_q;
		end else if (state_q == S_GAP && gi_q != pos_q) begin
			gi_q <= gi_q + ADDR_W'(1);
			gp_q <= gp_q + 32'(SEQ_STEP);
		end
		if (state_q == S_ED && div_done) begin
			pm_q <= (div_quot > NUM_W'(PM_SCALE)) ? 10'(PM_SCALE) : div_quot[9:0];
		end else if (state_q == S_EM) begin
			pm_q <= 10'd0;
		end
		if (state_q == S_EO) begin
			rsp_q <= '{kind: 1'b1, need_resend: 1'b0, tracking: 1'b1, stat_id: k_q,
				count: sel_cnt, per_mille: pm_q, span_first: first_q,
				span_last: lastv_q, last: (k_q == SID_GETS)};
		end else if (state_q == S_MKD) begin
			rsp_q <= '{kind: 1'b0, need_resend: (e_mark != s_q),
				tracking: (newest_q != 32'd0), stat_id: SID_TOTAL, count: 20'd0,
				per_mille: 10'd0, span_first: 32'd0, span_last: 32'd0, last: 1'b1};
		end
	end

	// control and store state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			flag1_q     <= 1'b0;
			updn_q      <= 1'b0;
			newest_q    <= 32'd0;
			vmain_q     <= '0;
			vmark_q     <= '0;
			vmain_rd_q  <= 1'b0;
			vmark_rd_q  <= 1'b0;
			walk_q      <= '0;
			pend_q      <= 1'b0;
			first_q     <= 32'd0;
			lastv_q     <= 32'd0;
			k_q         <= 4'd0;
			rsp_valid_q <= 1'b0;
			for (int i = 0; i < NUM_STATS; i++) begin
				cnt_q[i] <= '0;
			end
		end else begin
			rsp_valid_q <= 1'b0;
			if (m_re) begin
				vmain_rd_q <= vmain_q[raddr];
			end
			if (k_re) begin
				vmark_rd_q <= vmark_q[raddr];
			end
			// a clear may keep the one entry written in the same cycle
			if (clr) begin
				vmain_q  <= m_we ? (RING_DEPTH'(1) << m_waddr) : '0;
				vmark_q  <= '0;
				newest_q <= 32'd0;
			end else begin
				if (m_we) begin
					vmain_q[m_waddr] <= 1'b1;
				end
				if (k_we) begin
					vmark_q[pos_q] <= 1'b1;
				end
			end

			// accumulate one walked entry
			if (pend_q && e_st != ST_INIT) begin
				if (e_seq > lastv_q) begin
					lastv_q <= e_seq;
				end
				if (e_seq < first_q && e_seq != 32'd0) begin
					first_q <= e_seq;
				end
				if ((e_st == ST_REAL_LOSS || e_st == ST_LOSS) && e_mark == e_seq) begin
					cnt_q[SID_SPEAKER] <= cnt_q[SID_SPEAKER] + CNT_W'(1);
				end
				cnt_q[SID_EMPTIES] <= cnt_q[SID_EMPTIES] + CNT_W'(e_ecnt);
				case (e_st) inside
					ST_LOSS, ST_REAL_LOSS: begin
						cnt_q[SID_LOSS] <= cnt_q[SID_LOSS] + CNT_W'(1);
					end
					ST_SUCC: begin
						cnt_q[SID_FIRST] <= cnt_q[SID_FIRST] + CNT_W'(1);
						cnt_q[SID_SUCC]  <= cnt_q[SID_SUCC] + CNT_W'(1);
					end
					ST_RS_OK: begin
						cnt_q[SID_SUCC]  <= cnt_q[SID_SUCC] + CNT_W'(1);
						cnt_q[SID_RS_OK] <= cnt_q[SID_RS_OK] + CNT_W'(1);
					end
					ST_RS_EXCESS: begin
						cnt_q[SID_FIRST]  <= cnt_q[SID_FIRST] + CNT_W'(1);
						cnt_q[SID_SUCC]   <= cnt_q[SID_SUCC] + CNT_W'(1);
						cnt_q[SID_EXCESS] <= cnt_q[SID_EXCESS] + CNT_W'(1);
					end
					ST_RS_LATE: begin
						cnt_q[SID_RS_LATE] <= cnt_q[SID_RS_LATE] + CNT_W'(1);
						cnt_q[SID_LOSS]    <= cnt_q[SID_LOSS] + CNT_W'(1);
					end
					ST_RS_ERROR: begin
						cnt_q[SID_RS_ERR] <= cnt_q[SID_RS_ERR] + CNT_W'(1);
						cnt_q[SID_LOSS]   <= cnt_q[SID_LOSS] + CNT_W'(1);
					end
					default: begin
					end
				endcase
			end else if (pend_q) begin
				cnt_q[SID_UNINIT] <= cnt_q[SID_UNINIT] + CNT_W'(1);
			end

			unique case (state_q)
				S_IDLE: begin
					if (qin.valid) begin
						flag1_q <= 1'b0;
						case (qin.cmd.op)
							OP_RECORD: state_q <= S_N;
							OP_COUNT:  state_q <= S_P1;
							OP_MARK:   state_q <= S_M2;
							OP_QUERY:  state_q <= S_MK;
							default: begin
								if (newest_q != 32'd0) begin
									state_q <= S_W;
								end
								walk_q  <= '0;
								first_q <= newest_q;
								lastv_q <= 32'd0;
								for (int i = 0; i < NUM_STATS; i++) begin
									cnt_q[i] <= '0;
								end
							end
						endcase
					end
				end
				S_P1: state_q <= S_P1D;
				S_P1D: begin
					if (e_seq >= s_q) begin
						state_q <= S_IDLE;
					end else begin
						flag1_q <= 1'b1;
						state_q <= S_N;
					end
				end
				S_N: state_q <= (newest_q != 32'd0) ? S_ND : S_R;
				S_ND: state_q <= clr ? S_IDLE : S_R;
				S_R: state_q <= S_RD;
				S_RD: begin
					if (e_seq == s_q) begin
						state_q <= S_IDLE;
					end else begin
						updn_q  <= (newest_q == 32'd0) || (newest_q < s_q);
						state_q <= (newest_q != 32'd0 && newest_q < s_q) ? S_GAP : S_WR;
					end
				end
				S_GAP: begin
					if (gi_q == pos_q) begin
						state_q <= S_WR;
					end
				end
				S_WR: begin
					if (updn_q) begin
						newest_q <= s_q;
					end
					state_q <= S_IDLE;
				end
				S_M2: state_q <= S_IDLE;
				S_MK: state_q <= S_MKD;
				S_MKD: begin
					rsp_valid_q <= 1'b1;
					state_q     <= S_IDLE;
				end
				S_W: begin
					if (m_re) begin
						walk_q <= walk_q + WIDX_W'(1);
						pend_q <= 1'b1;
					end else begin
						pend_q  <= 1'b0;
						state_q <= S_WFIN;
					end
				end
				S_WFIN: begin
					cnt_q[SID_TOTAL] <= CNT_W'(REPORT_WINDOW) - cnt_q[SID_UNINIT];
					cnt_q[SID_GETS]  <= cnt_q[SID_SPEAKER] + cnt_q[SID_SUCC];
					k_q     <= 4'd0;
					state_q <= S_EM;
				end
				S_EM: state_q <= div_start ? S_ED : S_EO;
				S_ED: begin
					if (div_done) begin
						state_q <= S_EO;
					end
				end
				S_EO: begin
					rsp_valid_q <= 1'b1;
					k_q         <= k_q + 4'd1;
					state_q     <= (k_q == SID_GETS) ? S_IDLE : S_EM;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

/* src/packet_loss_window_tracker.sv */
// ----------------------------------------------------------------------------
// packet_loss_window_tracker
// Ring of per-sequence delivery entries with gap fill, empty counts,
// resend queries and a twelve-counter report over a window of entries.
// ----------------------------------------------------------------------------
// In the back end a mark is one write; a resend query reads the mark and answers; a record
// or empty count reads the ring, may fill a gap with losses one entry at a time and then
// writes its entry. Report: a walk of the window, then each counter run through the
// 18-step divider or, for the empty count or an empty window, not divided.
// One item in the back end at a time; results cannot be stalled. Reset empties the ring
// through per-entry valid flops.
module packet_loss_window_tracker
	import plwt_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  req_t req,
	output logic rsp_valid,
	output rsp_t rsp
);

	queue_out_t qout;
	logic       pop;

	// front: accept, classify, queue
	plwt_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.pop    (pop),
		.qout   (qout)
	);

	// back: execute against the ring and emit results
	plwt_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.qin       (qout),
		.pop       (pop),
		.rsp_valid (rsp_valid),
		.rsp       (rsp)
	);

endmodule

/* src/plwt_checker.sv */
// ----------------------------------------------------------------------------
// plwt_checker
// Port-level checks on the result stream of the tracker.
// ----------------------------------------------------------------------------
module plwt_checker
	import plwt_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic rsp_valid,
	input rsp_t rsp
);

	a_query_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.kind |-> rsp.last)
		else $error("resend answer without last");

	a_report_tracking: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.kind |-> rsp.tracking && !rsp.need_resend)
		else $error("report result while not tracking");

	a_report_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.kind |-> (rsp.last == (rsp.stat_id == SID_GETS)))
		else $error("last flag off the final statistic");

	a_pm_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.kind |-> rsp.per_mille <= 10'(PM_SCALE))
		else $error("share above full scale");

endmodule

bind packet_loss_window_tracker plwt_checker u_plwt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp_valid),
	.rsp       (rsp)
);

/* tb/tb_packet_loss_window_tracker.sv */
// ----------------------------------------------------------------------------
// tb_packet_loss_window_tracker
// Self-checking bench: a local predictor of the ring tracker computes the
// expected resend answers and report counters for each accepted item; a
// checker compares every strobed result field by field against them.
// ----------------------------------------------------------------------------
module tb_packet_loss_window_tracker
	import plwt_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int  CYCLE_LIMIT = 1500000;
	localparam int  RAND_ITEMS  = 480;
	localparam int  DRAIN_WAIT  = 400;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	req_t req;
	logic rsp_valid;
	rsp_t rsp;

	packet_loss_window_tracker DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp      (rsp)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Predictor copy of the ring and newest sequence.
	logic [3:0]  ring_status [RING_DEPTH];
	logic [31:0] ring_seq    [RING_DEPTH];
	logic [15:0] ring_ecnt   [RING_DEPTH];
	logic [31:0] ring_mark   [RING_DEPTH];
	logic [31:0] newest;

	rsp_t pending_results[$];
	int   errors;
	int   cycles;
	int   idle_pct;

	function automatic int ring_pos(logic [31:0] s);
		return (s / SEQ_STEP) % RING_DEPTH;
	endfunction

	function automatic void wipe_ring();
		for (int i = 0; i < RING_DEPTH; i++) begin
			ring_status[i] = ST_INIT;
			ring_seq[i]    = '0;
			ring_ecnt[i]   = '0;
			ring_mark[i]   = '0;
		end
		newest = '0;
	endfunction

	function automatic void track_packet(logic [31:0] s, logic [3:0] st);
		int          pos;
		int          lastpos;
		int          i;
		logic        tracked;
		logic [31:0] jump_dist;
		logic [31:0] p;
		logic [3:0]  old;
		pos = ring_pos(s);
		tracked = (newest != 0);
		lastpos = 0;
		if (tracked) begin
			lastpos = ring_pos(newest);
			// Drop everything on a broken ring or a jump past the limit.
			if (ring_seq[lastpos] != newest) begin
				wipe_ring();
				return;
			end
			jump_dist = (s > newest) ? s - newest : newest - s;
			if (jump_dist > MAX_JUMP) begin
				wipe_ring();
				return;
			end
		end
		if (ring_seq[pos] == s) begin
			old = ring_status[pos];
			if (old != ST_RS_OK && old != ST_SUCC)
				ring_status[pos] = st;
			else if (old == ST_SUCC && st == ST_RS_LATE)
				ring_status[pos] = ST_RS_EXCESS;
			return;
		end
		if (!tracked || newest < s) begin
			if (tracked) begin
				// Fill the gap up to the newer sequence with losses.
				p = newest;
				i = (lastpos + 1) % RING_DEPTH;
				while (i != pos) begin
					p += SEQ_STEP;
					ring_status[i] = ST_LOSS;
					ring_seq[i]    = p;
					ring_ecnt[i]   = '0;
					i = (i + 1) % RING_DEPTH;
				end
			end
			newest = s;
		end
		ring_status[pos] = st;
		ring_seq[pos]    = s;
		ring_ecnt[pos]   = '0;
	endfunction

	function automatic void predict_item(req_t r);
		int          pos;
		int          p;
		logic [3:0]  st;
		logic [63:0] c [NUM_STATS];
		logic [31:0] first;
		logic [31:0] lastv;
		logic [31:0] es;
		logic [63:0] pm;
		logic [19:0] cnt;
		rsp_t        res;
		pos = ring_pos(r.seq);
		case (r.op)
			OP_RECORD: begin
				if (r.is_resend) st = r.is_loss ? ST_RS_LATE : ST_RS_OK;
				else st = r.is_loss ? ST_REAL_LOSS : ST_SUCC;
				track_packet(r.seq, st);
			end
			OP_COUNT: begin
				if (ring_seq[pos] == r.seq) begin
					if (ring_ecnt[pos] != 16'hFFFF) ring_ecnt[pos]++;
				end else if (ring_seq[pos] < r.seq) begin
					track_packet(r.seq, ST_LOSS);
					ring_ecnt[pos] = 16'd1;
				end
			end
			OP_MARK: ring_mark[pos] = r.seq;
			OP_QUERY: begin
				res = '0;
				res.need_resend = (ring_mark[pos] != r.seq);
				res.tracking    = (newest != 0);
				res.last        = 1'b1;
				pending_results.push_back(res);
			end
			OP_REPORT: begin
				if (newest == 0) return;
				foreach (c[k]) c[k] = '0;
				c[SID_TOTAL] = REPORT_WINDOW;
				first = newest;
				lastv = '0;
				for (int i = 0; i < REPORT_WINDOW; i++) begin
					p  = ring_pos(r.seq - 32'(i * WALK_STEP));
					st = ring_status[p];
					es = ring_seq[p];
					if (st == ST_INIT) begin
						c[SID_TOTAL]--;
						c[SID_UNINIT]++;
						continue;
					end
					if (es > lastv) lastv = es;
					if (es < first && es != 0) first = es;
					if ((st == ST_REAL_LOSS || st == ST_LOSS) && ring_mark[p] == es)
						c[SID_SPEAKER]++;
					c[SID_EMPTIES] += ring_ecnt[p];
					case (st)
						ST_LOSS: c[SID_LOSS]++;
						ST_SUCC: begin
							c[SID_FIRST]++;
							c[SID_SUCC]++;
						end
						ST_RS_OK: begin
							c[SID_SUCC]++;
							c[SID_RS_OK]++;
						end
						ST_RS_EXCESS: begin
							c[SID_FIRST]++;
							c[SID_SUCC]++;
							c[SID_EXCESS]++;
						end
						ST_RS_LATE: begin
							c[SID_RS_LATE]++;
							c[SID_LOSS]++;
						end
						ST_RS_ERROR: begin
							c[SID_RS_ERR]++;
							c[SID_LOSS]++;
						end
						ST_REAL_LOSS: c[SID_LOSS]++;
						default: ;
					endcase
				end
				c[SID_GETS] = c[SID_SPEAKER] + c[SID_SUCC];
				for (int k = 0; k < NUM_STATS; k++) begin
					cnt = (c[k] > COUNT_MAX) ? COUNT_MAX : c[k][19:0];
					pm = '0;
					if (c[SID_TOTAL] != 0 && k != SID_EMPTIES) begin
						pm = 64'(cnt) * PM_SCALE / c[SID_TOTAL];
						if (pm > PM_SCALE) pm = PM_SCALE;
					end
					res = '0;
					res.kind       = 1'b1;
					res.tracking   = 1'b1;
					res.stat_id    = 4'(k);
					res.count      = cnt;
					res.per_mille  = pm[9:0];
					res.span_first = first;
					res.span_last  = lastv;
					res.last       = (k == NUM_STATS - 1);
					pending_results.push_back(res);
				end
			end
			default: ;
		endcase
	endfunction

	// Check each strobed result against the oldest expectation.
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp_valid) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result kind=%0d stat_id=%0d", rsp.kind, rsp.stat_id);
				errors++;
			end else begin
				want = pending_results.pop_front();
				if (rsp.kind != want.kind) begin
					$error("kind exp %0d got %0d", want.kind, rsp.kind);
					errors++;
				end
				if (rsp.need_resend != want.need_resend) begin
					$error("need_resend exp %0d got %0d", want.need_resend, rsp.need_resend);
					errors++;
				end
				if (rsp.tracking != want.tracking) begin
					$error("tracking exp %0d got %0d", want.tracking, rsp.tracking);
					errors++;
				end
				if (rsp.stat_id != want.stat_id) begin
					$error("stat_id exp %0d got %0d", want.stat_id, rsp.stat_id);
					errors++;
				end
				if (rsp.count != want.count) begin
					$error("count exp %0d got %0d", want.count, rsp.count);
					errors++;
				end
				if (rsp.per_mille != want.per_mille) begin
					$error("per_mille exp %0d got %0d", want.per_mille, rsp.per_mille);
					errors++;
				end
				if (rsp.span_first != want.span_first) begin
					$error("span_first exp %0h got %0h", want.span_first, rsp.span_first);
					errors++;
				end
				if (rsp.span_last != want.span_last) begin
					$error("span_last exp %0h got %0h", want.span_last, rsp.span_last);
					errors++;
				end
				if (rsp.last != want.last) begin
					$error("last exp %0d got %0d", want.last, rsp.last);
					errors++;
				end
			end
		end
	end

	// Watchdog on total run length.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Hold start until the item is taken; drop it only while idling.
	task automatic send_item(logic [2:0] op, logic [31:0] s, logic loss, logic rs);
		req_t item;
		item = '{op: op, seq: s, is_loss: loss, is_resend: rs};
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		req   <= item;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		predict_item(item);
	endtask

	task automatic test_directed();
		// Zero record does not start tracking; report then yields nothing.
		send_item(OP_RECORD, 32'd0, 1'b0, 1'b0);
		send_item(OP_REPORT, 32'd0, 1'b0, 1'b0);
		send_item(OP_QUERY, 32'd0, 1'b0, 1'b0);
		send_item(OP_RECORD, 32'd10, 1'b0, 1'b0);
		send_item(OP_RECORD, 32'd20, 1'b1, 1'b0);
		send_item(OP_RECORD, 32'd14, 1'b1, 1'b1);
		send_item(OP_RECORD, 32'd10, 1'b1, 1'b1);
		send_item(OP_RECORD, 32'd16, 1'b0, 1'b1);
		send_item(OP_COUNT, 32'd20, 1'b0, 1'b0);
		send_item(OP_COUNT, 32'd24, 1'b0, 1'b0);
		send_item(OP_COUNT, 32'd2, 1'b0, 1'b0);
		send_item(OP_MARK, 32'd12, 1'b0, 1'b0);
		send_item(OP_QUERY, 32'd12, 1'b0, 1'b0);
		send_item(OP_QUERY, 32'd13, 1'b0, 1'b0);
		send_item(OP_REPORT, 32'd24, 1'b0, 1'b0);
		// Unknown ops are ignored.
		send_item(3'd5, 32'hFFFF_FFFF, 1'b1, 1'b1);
		send_item(3'd7, 32'd24, 1'b0, 1'b0);
		// Report window wraps below zero.
		send_item(OP_REPORT, 32'd4, 1'b0, 1'b0);
		// Jump too far clears the store.
		send_item(OP_RECORD, 32'd400, 1'b0, 1'b0);
		send_item(OP_RECORD, 32'hFFFF_FFF0, 1'b1, 1'b0);
		send_item(OP_RECORD, 32'hFFFF_FFFE, 1'b0, 1'b1);
		send_item(OP_REPORT, 32'hFFFF_FFFF, 1'b0, 1'b0);
		send_item(OP_RECORD, 32'h0000_0070, 1'b0, 1'b0);
		send_item(OP_QUERY, 32'hFFFF_FFFF, 1'b0, 1'b0);
	endtask

	task automatic test_random(int n);
		logic [31:0] base;
		logic [31:0] s;
		int          r;
		base = $urandom_range(1, 32'h7FFF_FFFF) & ~32'd1;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(99);
			// Mostly sequences near the newest one, some wild noise.
			if (r < 8) s = $urandom();
			else if (r < 12) base = $urandom() & ~32'd1;
			else begin
				s = base + 32'($urandom_range(0, 40)) - 32'd16;
				if ($urandom_range(3) == 0) s |= 32'd1;
				if ($urandom_range(2) == 0) base = base + 32'($urandom_range(0, 12));
			end
			if (r >= 8) s = (r < 12) ? base : s;
			r = $urandom_range(99);
			if (r < 45) send_item(OP_RECORD, s, 1'($urandom()), 1'($urandom()));
			else if (r < 60) send_item(OP_COUNT, s, 1'($urandom()), 1'($urandom()));
			else if (r < 70) send_item(OP_MARK, s, 1'b0, 1'b0);
			else if (r < 83) send_item(OP_QUERY, s, 1'b0, 1'b0);
			else if (r < 95) send_item(OP_REPORT, base + 32'($urandom_range(0, 8)), 1'b0,
				1'b0);
			else send_item(3'($urandom_range(5, 7)), $urandom(), 1'($urandom()),
				1'($urandom()));
		end
	endtask

	// Pile empty counts onto one sequence and report them.
	task automatic test_empty_saturation();
		send_item(OP_RECORD, 32'h100, 1'b0, 1'b0);
		for (int i = 0; i < 40; i++)
			send_item(OP_COUNT, 32'h100, 1'b0, 1'b0);
		send_item(OP_REPORT, 32'h100, 1'b0, 1'b0);
	endtask

	initial begin
		errors   = 0;
		cycles   = 0;
		idle_pct = 12;
		arst_n   = 1'b0;
		start    = 1'b0;
		req      = '0;
		wipe_ring();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_empty_saturation();
		test_random(RAND_ITEMS / 3);
		idle_pct = 49;
		test_random(RAND_ITEMS / 3);
		idle_pct = 0;
		test_random(RAND_ITEMS / 3);
		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (errors == 0 && pending_results.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

/* filelist.f */
src/plwt_pkg.sv
src/plwt_ram.sv
src/plwt_front.sv
src/plwt_div.sv
src/plwt_back.sv
src/packet_loss_window_tracker.sv
src/plwt_checker.sv
tb/tb_packet_loss_window_tracker.sv
